// ===== hw/rtl/lsts_pkg.sv =====
package lsts_pkg;

	localparam int unsigned LOGIT_W  = 16;
	localparam int unsigned TARGET_W = 18;
	localparam int unsigned VOCAB_W  = 19;
	localparam int unsigned PROB_W   = 18;
	localparam int unsigned SUM_W    = 40;
	localparam int unsigned LN_W     = 14;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [15:0] LN2_Q16   = 16'd45426;
	localparam longint unsigned LN2_Q32 = 64'd2977044472;

	typedef struct packed {
		logic load;
		logic pass_rd;
		logic tgt_rd;
		logic tgt_cap;
		logic norm_start;
		logic norm_step;
		logic ln_rom;
		logic ln_mul;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic rd_last;
		logic pipe_empty;
		logic norm_done;
		logic out_full;
	} stat_t;

	function automatic longint unsigned div_small(longint unsigned v, int k);
		longint unsigned q;
		case (k)
			1: q = v / 1;
			2: q = v / 2;
			3: q = v / 3;
			4: q = v / 4;
			5: q = v / 5;
			6: q = v / 6;
			7: q = v / 7;
			8: q = v / 8;
			9: q = v / 9;
			10: q = v / 10;
			11: q = v / 11;
			12: q = v / 12;
			13: q = v / 13;
			14: q = v / 14;
			15: q = v / 15;
			16: q = v / 16;
			17: q = v / 17;
			18: q = v / 18;
			19: q = v / 19;
			20: q = v / 20;
			21: q = v / 21;
			22: q = v / 22;
			23: q = v / 23;
			default: q = v / 24;
		endcase
		return q;
	endfunction

	// 2^(-i/2^tb) in q.16, series for exp in q32
	function automatic longint unsigned exp_entry(int i, int tb);
		longint unsigned y;
		longint unsigned sum;
		longint unsigned term;
		longint unsigned tsize;
		tsize = longint'(1) << tb;
		y = (LN2_Q32 * (tsize - longint'(i))) >> tb;
		sum = longint'(1) << 32;
		term = longint'(1) << 32;
		for (int k = 1; k <= 24; k++) begin
			term = div_small((term * y) >> 32, k);
			sum = sum + term;
		end
		return (sum + (longint'(1) << 16)) >> 17;
	endfunction

	// log2(1 + i/2^tb) in q.16 by repeated squaring
	function automatic longint unsigned log_entry(int i, int tb);
		longint unsigned x;
		longint unsigned r;
		x = ((longint'(1) << tb) + longint'(i)) << (30 - tb);
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			x = (x * x) >> 30;
			if (x >= (longint'(1) << 31)) begin
				x = x >> 1;
				r = r | (longint'(1) << b);
			end
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/lsts_if.sv =====
interface lsts_logit_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] logit_value;
	logic        [17:0] target_index;

	modport source (output valid, logit_value, target_index, input ready);
	modport sink (input valid, logit_value, target_index, output ready);
endinterface

interface lsts_result_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] log_prob;
	logic               target_invalid;

	modport source (output valid, log_prob, target_invalid, input ready);
	modport sink (input valid, log_prob, target_invalid, output ready);
endinterface

interface lsts_cfg_if;
	logic        valid;
	logic        ready;
	logic [18:0] vocab_count;

	modport source (output valid, vocab_count, input ready);
	modport sink (input valid, vocab_count, output ready);
endinterface

// ===== hw/rtl/lsts_datapath.sv =====
module lsts_datapath #(
	parameter int unsigned VOCAB_DEPTH    = 262144,
	parameter int unsigned EXP_TABLE_BITS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lsts_pkg::cmd_t                         cmd,
	output lsts_pkg::stat_t                        st,
	input  logic signed [lsts_pkg::LOGIT_W-1:0]    logit_value,
	input  logic        [lsts_pkg::TARGET_W-1:0]   target_index,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic        [lsts_pkg::VOCAB_W-1:0]    cfg_vocab_count,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [lsts_pkg::PROB_W-1:0]     out_log_prob,
	output logic                                   out_target_invalid
);
	import lsts_pkg::*;

	localparam int unsigned AW   = $clog2(VOCAB_DEPTH);
	localparam int unsigned CW   = AW + 1;
	localparam int unsigned CMPW = (CW > VOCAB_W) ? CW : VOCAB_W;
	localparam int unsigned TBL  = 1 << EXP_TABLE_BITS;

	logic [16:0] exp_rom [TBL];
	logic [15:0] log_rom [TBL];

	for (genvar g = 0; g < TBL; g++) begin : g_rom
		assign exp_rom[g] = 17'(exp_entry(g, EXP_TABLE_BITS));
		assign log_rom[g] = 16'(log_entry(g, EXP_TABLE_BITS));
	end

	logic [LOGIT_W-1:0] mem [VOCAB_DEPTH];

	logic [VOCAB_W-1:0]        vocab_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             rd_q;
	logic signed [LOGIT_W-1:0] max_q;
	logic [TARGET_W-1:0]       target_q;
	logic signed [LOGIT_W-1:0] tlogit_q;
	logic [SUM_W-1:0]          sum_q;
	logic [SUM_W-1:0]          norm_q;
	logic [5:0]                p_q;
	logic [21:0]               l2_q;
	logic [LN_W-1:0]           ln_q;
	logic                      out_valid_q;
	logic signed [PROB_W-1:0]  lp_q;
	logic                      inv_q;

	logic [LOGIT_W-1:0] rdata_s1;
	logic               v_s1;
	logic [32:0]        u_s2;
	logic               v_s2;
	logic [16:0]        rom_s3;
	logic [8:0]         k_s3;
	logic               v_s3;

	logic [AW-1:0]   wr_addr;
	logic [CW-1:0]   next_count;
	logic [CMPW-1:0] vc;
	logic [CMPW-1:0] n_clamp;
	logic [CMPW-1:0] tgt_ext;
	logic            tgt_bad;
	logic [16:0]     diff17;
	logic [16:0]     term;
	logic [SUM_W:0]  sum_add;
	logic [37:0]     ln_prod;
	logic [18:0]     lp19;

	always_comb begin
		if (count_q >= CW'(VOCAB_DEPTH)) begin
			wr_addr = AW'(VOCAB_DEPTH - 1);
		end else begin
			wr_addr = count_q[AW-1:0];
		end
		next_count = CW'(wr_addr) + CW'(1);
		vc = CMPW'(vocab_q);
		if (vc < CMPW'(2)) begin
			n_clamp = CMPW'(2);
		end else if (vc > CMPW'(VOCAB_DEPTH)) begin
			n_clamp = CMPW'(VOCAB_DEPTH);
		end else begin
			n_clamp = vc;
		end
		tgt_ext = CMPW'(target_q);
		tgt_bad = tgt_ext >= CMPW'(count_q);
		diff17 = {max_q[LOGIT_W-1], max_q} - {rdata_s1[LOGIT_W-1], rdata_s1};
		if (k_s3 > 9'd16) begin
			term = '0;
		end else begin
			term = rom_s3 >> k_s3[4:0];
		end
		sum_add = {1'b0, sum_q} + (SUM_W + 1)'(term);
		ln_prod = 38'(l2_q) * 38'(LN2_Q16) + 38'(1 << 23);
		lp19 = {{3{tlogit_q[LOGIT_W-1]}}, tlogit_q} - {{3{max_q[LOGIT_W-1]}}, max_q}
			- 19'(ln_q);
	end

	assign st.last       = CMPW'(next_count) >= n_clamp;
	assign st.rd_last    = (rd_q + CW'(1)) == count_q;
	assign st.pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign st.norm_done  = norm_q[SUM_W-1] || (p_q == 6'd16);
	assign st.out_full   = out_valid_q;

	assign cfg_ready          = 1'b1;
	assign out_valid          = out_valid_q;
	assign out_log_prob       = lp_q;
	assign out_target_invalid = inv_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[wr_addr] <= logit_value;
		end
		if (cmd.pass_rd) begin
			rdata_s1 <= mem[rd_q[AW-1:0]];
		end else if (cmd.tgt_rd) begin
			rdata_s1 <= mem[tgt_ext[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		u_s2   <= 33'(diff17[15:0]) * 33'(LOG2E_Q16);
		rom_s3 <= exp_rom[u_s2[23 -: EXP_TABLE_BITS]];
		k_s3   <= u_s2[32:24];
		if (cmd.load) begin
			target_q <= target_index;
		end
		if (cmd.tgt_cap) begin
			tlogit_q <= rdata_s1;
		end
		if (cmd.ln_rom) begin
			l2_q <= 22'({p_q - 6'd16, 16'h0000}) + 22'(log_rom[norm_q[SUM_W-2 -: EXP_TABLE_BITS]]);
		end
		if (cmd.ln_mul) begin
			ln_q <= ln_prod[24 +: LN_W];
		end
		if (cmd.norm_start) begin
			norm_q <= sum_q;
		end else if (cmd.norm_step) begin
			norm_q <= {norm_q[SUM_W-2:0], 1'b0};
		end
		if (cmd.out_load) begin
			inv_q <= tgt_bad;
			if (tgt_bad) begin
				lp_q <= '0;
			end else if (lp19[18] && !lp19[17]) begin
				lp_q <= {1'b1, {(PROB_W-1){1'b0}}};
			end else begin
				lp_q <= lp19[PROB_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_q     <= 19'h40000;
			count_q     <= '0;
			rd_q        <= '0;
			max_q       <= {1'b1, {(LOGIT_W-1){1'b0}}};
			sum_q       <= '0;
			p_q         <= 6'd39;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				vocab_q <= cfg_vocab_count;
			end
			v_s1 <= cmd.pass_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.load) begin
				count_q <= next_count;
				if (logit_value > max_q) begin
					max_q <= logit_value;
				end
			end
			if (cmd.pass_rd) begin
				rd_q <= rd_q + CW'(1);
			end
			if (v_s3) begin
				sum_q <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
			end
			if (cmd.norm_start) begin
				p_q <= 6'd39;
			end else if (cmd.norm_step) begin
				p_q <= p_q - 6'd1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				rd_q        <= '0;
				max_q       <= {1'b1, {(LOGIT_W-1){1'b0}}};
				sum_q       <= '0;
			end
		end
	end

endmodule

// ===== hw/rtl/lsts_ctrl.sv =====
module lsts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lsts_pkg::stat_t st,
	output lsts_pkg::cmd_t  cmd
);
	import lsts_pkg::*;

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_PASS  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_TGT   = 3'd3;
	localparam logic [2:0] S_NORM  = 3'd4;
	localparam logic [2:0] S_LNM   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_LOAD);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (st.last) begin
						state_d = S_PASS;
					end
				end
			end
			S_PASS: begin
				cmd.pass_rd = 1'b1;
				if (st.rd_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (st.pipe_empty) begin
					cmd.tgt_rd = 1'b1;
					state_d = S_TGT;
				end
			end
			S_TGT: begin
				cmd.tgt_cap = 1'b1;
				cmd.norm_start = 1'b1;
				state_d = S_NORM;
			end
			S_NORM: begin
				if (st.norm_done) begin
					cmd.ln_rom = 1'b1;
					state_d = S_LNM;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			S_LNM: begin
				cmd.ln_mul = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!st.out_full) begin
					cmd.out_load = 1'b1;
					state_d = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !st.out_full) else $error("result loaded over a full output");
	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.norm_step |-> !st.norm_done) else $error("normalize past leading one");
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> (!cmd.pass_rd && !cmd.norm_step && !cmd.tgt_rd))
		else $error("second pass activity while loading");
	a_tgt_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tgt_rd |=> (state_q == S_TGT)) else $error("target read out of sequence");

endmodule

// ===== hw/rtl/log_softmax_target_score.sv =====
// Log softmax of one target logit. Logits are taken one per cycle until the vector
// (vocab_count, clamped to 2..VOCAB_DEPTH) is complete; the target_index on the last
// request is used. Then the block reads the stored vector back through one memory
// port, one entry per cycle, followed by a pipeline drain, a target read and capture,
// a leading-one search whose final step also reads the log table, and the log
// multiply and result. Input is held off during the readback.
// The result register lets the next vector load while a result waits.
module log_softmax_target_score #(
	parameter int unsigned VOCAB_DEPTH    = 262144,
	parameter int unsigned EXP_TABLE_BITS = 10
) (
	input logic          clk,
	input logic          arst_n,
	lsts_logit_if.sink   logits,
	lsts_result_if.source result,
	lsts_cfg_if.sink     cfg
);
	import lsts_pkg::*;

	cmd_t  cmd;
	stat_t st;

	lsts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (logits.valid),
		.in_ready (logits.ready),
		.st       (st),
		.cmd      (cmd)
	);

	lsts_datapath #(
		.VOCAB_DEPTH    (VOCAB_DEPTH),
		.EXP_TABLE_BITS (EXP_TABLE_BITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.st                 (st),
		.logit_value        (logits.logit_value),
		.target_index       (logits.target_index),
		.cfg_valid          (cfg.valid),
		.cfg_ready          (cfg.ready),
		.cfg_vocab_count    (cfg.vocab_count),
		.out_valid          (result.valid),
		.out_ready          (result.ready),
		.out_log_prob       (result.log_prob),
		.out_target_invalid (result.target_invalid)
	);

endmodule

// ===== sim/tb_log_softmax_target_score.sv =====
module tb_log_softmax_target_score;
	timeunit 1ns;
	timeprecision 1ps;

	import lsts_pkg::*;

	localparam int unsigned DEPTH      = 262144;
	localparam int unsigned TBITS      = 10;
	localparam int unsigned TSIZE      = 1 << TBITS;
	localparam int unsigned SETTLE     = 40;
	localparam int unsigned CYCLE_CAP  = 4000000;
	localparam int unsigned HOLD_LEN   = 300;
	localparam logic [18:0] VOCAB_MAX  = 19'h7FFFF;

	typedef struct {
		logic signed [17:0] log_prob;
		logic               target_invalid;
	} score_t;

	typedef struct {
		bit                 is_cfg;
		logic [18:0]        vocab;
		logic signed [15:0] logit;
		logic [17:0]        target;
		bit                 fixed;
		score_t             score;
	} row_t;

	logic clk;
	logic arst_n;

	lsts_logit_if  logit_ch ();
	lsts_result_if res_ch ();
	lsts_cfg_if    cfg_ch ();

	log_softmax_target_score DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.logits (logit_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	longint unsigned exp2_frac_q16 [TSIZE];
	longint unsigned log2_mant_q16 [TSIZE];

	logic [15:0]        logit_mem [DEPTH];
	int unsigned        load_count;
	int                 vec_max;
	logic [18:0]        vocab_reg;

	score_t             score_q [$];
	row_t               rows [$];

	int unsigned        cycles;
	int unsigned        mismatches;
	int unsigned        scores_seen;
	int unsigned        items_sent;
	bit                 idle_en;
	bit                 press;
	bit                 held;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void build_tables();
		longint unsigned y, acc, term, x, r;
		for (int i = 0; i < TSIZE; i++) begin
			y = (LN2_Q32 * longint'(TSIZE - i)) >> TBITS;
			acc = 64'd1 << 32;
			term = 64'd1 << 32;
			for (int k = 1; k <= 24; k++) begin
				term = ((term * y) >> 32) / longint'(k);
				acc = acc + term;
			end
			exp2_frac_q16[i] = (acc + (64'd1 << 16)) >> 17;
			x = longint'(TSIZE + i) << (30 - TBITS);
			r = 0;
			for (int b = 15; b >= 0; b--) begin
				x = (x * x) >> 30;
				if (x >= (64'd1 << 31)) begin
					x = x >> 1;
					r = r | (64'd1 << b);
				end
			end
			log2_mant_q16[i] = r;
		end
	endfunction

	function automatic longint unsigned exp_weight(int gap);
		longint unsigned u, k, f;
		u = longint'(gap) * 94548;
		k = u >> 24;
		f = (u >> (24 - TBITS)) & (TSIZE - 1);
		if (k > 16)
			return 0;
		return exp2_frac_q16[f] >> k;
	endfunction

	function automatic longint unsigned ln_q8(longint unsigned s);
		int unsigned p;
		longint unsigned idx, l2;
		p = 16;
		while (p < 40 && (s >> (p + 1)) != 0)
			p++;
		idx = (s >> (p - TBITS)) & (TSIZE - 1);
		l2 = (longint'(p - 16) << 16) + log2_mant_q16[idx];
		return (l2 * 45426 + (64'd1 << 23)) >> 24;
	endfunction

	function automatic bit score_vector_step(logic signed [15:0] v, logic [17:0] tgt,
			output score_t sc);
		int unsigned n, slot, cnt;
		longint unsigned total;
		int lp;
		n = vocab_reg;
		if (n < 2)
			n = 2;
		if (n > DEPTH)
			n = DEPTH;
		slot = (load_count >= DEPTH) ? DEPTH - 1 : load_count;
		logit_mem[slot] = v;
		if (int'(v) > vec_max)
			vec_max = v;
		load_count = slot + 1;
		sc = '{0, 1'b0};
		if (load_count < n)
			return 1'b0;
		cnt = load_count;
		total = 0;
		for (int i = 0; i < cnt; i++) begin
			total += exp_weight(vec_max - int'($signed(logit_mem[i])));
			if (total > (64'd1 << 40) - 1)
				total = (64'd1 << 40) - 1;
		end
		if (tgt >= cnt) begin
			sc = '{0, 1'b1};
		end else begin
			lp = (int'($signed(logit_mem[tgt])) - vec_max) - int'(ln_q8(total));
			if (lp < -131072)
				lp = -131072;
			sc = '{lp[17:0], 1'b0};
		end
		load_count = 0;
		vec_max = -32768;
		return 1'b1;
	endfunction

	task automatic write_vocab(logic [18:0] val);
		logit_ch.valid <= 1'b0;
		while (score_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.vocab_count <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		vocab_reg = val;
	endtask

	task automatic send_logit(logic signed [15:0] v, logic [17:0] tgt, bit fixed,
			score_t typed);
		score_t sc;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			logit_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		logit_ch.valid        <= 1'b1;
		logit_ch.logit_value  <= v;
		logit_ch.target_index <= tgt;
		do
			@(posedge clk);
		while (!logit_ch.ready);
		items_sent++;
		if (score_vector_step(v, tgt, sc)) begin
			if (fixed)
				sc = typed;
			score_q = {score_q, sc};
		end
	endtask

	task automatic send_vector(int unsigned n, bit bad_target);
		int base;
		logic signed [15:0] v;
		logic [17:0] tgt;
		base = $urandom_range(0, 65535) - 32768;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0)
				v = 16'($urandom);
			else
				v = 16'(base + $urandom_range(0, 2047) - 1024);
			tgt = 18'($urandom);
			if (i == n - 1) begin
				if (!bad_target)
					tgt = 18'($urandom_range(0, n - 1));
				else if ($urandom_range(0, 1) == 0)
					tgt = 18'(n + $urandom_range(0, 3));
			end
			send_logit(v, tgt, 1'b0, '{0, 1'b0});
		end
	endtask

	task automatic add_cfg(logic [18:0] val);
		row_t row;
		row = '{1'b1, val, 16'sd0, 18'd0, 1'b0, '{0, 1'b0}};
		rows = {rows, row};
	endtask

	task automatic add_item(logic signed [15:0] v, logic [17:0] tgt, bit fixed,
			logic signed [17:0] lp, logic inv);
		row_t row;
		row = '{1'b0, 19'd0, v, tgt, fixed, '{lp, inv}};
		rows = {rows, row};
	endtask

	initial begin
		int unsigned n, reps;
		logit_ch.valid        <= 1'b0;
		logit_ch.logit_value  <= '0;
		logit_ch.target_index <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.vocab_count    <= '0;
		build_tables();
		load_count = 0;
		vec_max = -32768;
		vocab_reg = 19'd262144;
		idle_en = 1'b1;
		press = 1'b0;

		add_cfg(19'd2);
		add_item(16'sd100, 18'd0, 1'b0, 0, 1'b0);
		add_item(16'sd100, 18'd1, 1'b1, -18'sd177, 1'b0);
		add_item(16'sh7FFF, 18'd0, 1'b0, 0, 1'b0);
		add_item(-16'sh8000, 18'd1, 1'b1, -18'sd65535, 1'b0);
		add_item(16'sd5, 18'd0, 1'b0, 0, 1'b0);
		add_item(16'sd6, 18'd2, 1'b1, 18'sd0, 1'b1);
		add_item(16'sd7, 18'd0, 1'b0, 0, 1'b0);
		add_item(16'sd8, 18'h3FFFF, 1'b1, 18'sd0, 1'b1);
		add_cfg(19'd0);
		add_item(16'sd1, 18'd0, 1'b0, 0, 1'b0);
		add_item(16'sd2, 18'd1, 1'b0, 0, 1'b0);
		add_cfg(19'd5);
		for (int i = 0; i < 5; i++)
			add_item(16'(i * 300 - 600), 18'(i), 1'b0, 0, 1'b0);
		add_cfg(19'd10);
		for (int i = 0; i < 5; i++)
			add_item(16'(i * 50), 18'd0, 1'b0, 0, 1'b0);
		// shrink below the count already loaded
		add_cfg(19'd3);
		add_item(-16'sd20, 18'd5, 1'b0, 0, 1'b0);
		add_cfg(19'd1);
		add_item(-16'sd300, 18'd0, 1'b0, 0, 1'b0);
		add_item(16'sd300, 18'd0, 1'b0, 0, 1'b0);

		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				write_vocab(rows[i].vocab);
			else
				send_logit(rows[i].logit, rows[i].target, rows[i].fixed, rows[i].score);
		end

		while (items_sent < 1700) begin
			case ($urandom_range(0, 9))
				0: n = $urandom_range(0, 1);
				1: n = $urandom_range(60, 300);
				default: n = $urandom_range(2, 40);
			endcase
			write_vocab(19'(n));
			if (n < 2)
				n = 2;
			reps = $urandom_range(1, 4);
			for (int r = 0; r < reps; r++)
				send_vector(n, $urandom_range(0, 4) == 0);
			if (items_sent > 800 && !held) begin
				write_vocab(19'd8);
				press = 1'b1;
				for (int r = 0; r < 8; r++)
					send_vector(8, 1'b0);
				press = 1'b0;
			end
		end

		idle_en = 1'b0;
		write_vocab(19'd3);
		for (int r = 0; r < 10; r++)
			send_vector(3, r[0]);
		write_vocab(VOCAB_MAX);
		for (int i = 0; i < 40; i++)
			send_logit(16'($urandom), 18'($urandom_range(0, 45)), 1'b0, '{0, 1'b0});
		write_vocab(19'd3);
		send_logit(16'($urandom), 18'($urandom_range(0, 45)), 1'b0, '{0, 1'b0});
		logit_ch.valid <= 1'b0;

		while (score_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("%0d logits sent, %0d scores checked, vector sizes 2 to 300 plus an oversized setting",
			items_sent, scores_seen);
		$display("covered clamped sizes, mid-vector shrink, bad targets, output back-pressure");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		res_ch.ready <= 1'b0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!idle_en) begin
				res_ch.ready <= 1'b1;
			end else if (press && !held) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 2)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		score_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			scores_seen++;
			if (score_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected score %0d invalid %0b", res_ch.log_prob,
						res_ch.target_invalid);
			end else begin
				want = score_q.pop_front();
				if (res_ch.log_prob !== want.log_prob ||
						res_ch.target_invalid !== want.target_invalid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("score %0d: expected %0d/%0b got %0d/%0b", scores_seen,
							want.log_prob, want.target_invalid, res_ch.log_prob,
							res_ch.target_invalid);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("timeout, %0d scores pending", score_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/lsts_pkg.sv
hw/rtl/lsts_if.sv
hw/rtl/lsts_datapath.sv
hw/rtl/lsts_ctrl.sv
hw/rtl/log_softmax_target_score.sv
sim/tb_log_softmax_target_score.sv
